@@ design/mfalu_pkg.sv @@
// Shared types and constants for the multi-format integer ALU.
// No dependencies; imported by the core and its checker.
package mfalu_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int PROD_WIDTH = 2 * MAX_WIDTH;
    localparam int CFG_WIDTH  = 6;
    localparam int DIV_STAGES = MAX_WIDTH;
    // decode, multiply, one stage per quotient bit, result
    localparam int NUM_STAGES = DIV_STAGES + 3;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;
    typedef enum logic [1:0] {FMT_UNS, FMT_SM, FMT_OC, FMT_TC} fmt_t;
    typedef enum logic [1:0] {ST_OK, ST_OVF, ST_UNF, ST_DIVZ} status_t;

    typedef struct packed {
        op_t                     kind;
        fmt_t                    fmt;
        logic [CFG_WIDTH-1:0]    n;
        logic                    sa;
        logic                    sb;
        logic                    a_nz;
        logic                    b_nz;
        logic [MAX_WIDTH-1:0]    asr;
        status_t                 ast;
        logic [MAX_WIDTH-1:0]    ma;
        logic [MAX_WIDTH-1:0]    mb;
        logic [PROD_WIDTH-1:0]   prod;
        logic [MAX_WIDTH-1:0]    rem;
        logic [MAX_WIDTH-1:0]    dvd;
        logic [MAX_WIDTH-1:0]    q;
        logic [PROD_WIDTH-1:0]   res;
        status_t                 st;
    } pipe_t;

endpackage

@@ design/multi_format_integer_alu_core.sv @@
// Multi-format integer ALU core: add, subtract, multiply, divide in four formats.
// Depends on mfalu_pkg.
//
// One item per cycle unless the output stalls, through 35 register stages:
// a decode stage (add/subtract done here), a multiply stage, a 32-stage restoring
// divider that retires one quotient bit per stage, and a result stage. Every stage
// has its own valid bit and holds while the stage after it is full and cannot
// drain, so bubbles close up under output stalls. operand_width is written through
// cfg_valid/cfg_data (always ready) and should only change while the pipeline is
// empty.
module multi_format_integer_alu_core
    import mfalu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_WIDTH-1:0]  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [1:0]            number_format,
    input  logic [MAX_WIDTH-1:0]  operand_a,
    input  logic [MAX_WIDTH-1:0]  operand_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PROD_WIDTH-1:0] result_value,
    output logic [1:0]            status
);

    logic [CFG_WIDTH-1:0] width_reg;
    logic                 vld_reg [NUM_STAGES];
    pipe_t                stg_reg [NUM_STAGES];
    pipe_t                stg_next [NUM_STAGES];
    logic                 rdy [NUM_STAGES+1];

    // decode signals
    logic [CFG_WIDTH-1:0] n;
    logic [MAX_WIDTH-1:0] m, mm, sgnbit, a, b, ma, mb, bb, t1, tt;
    logic [MAX_WIDTH:0]   s, t;
    logic                 sa, sb, sbe, sbb, ts;
    op_t                  op;
    fmt_t                 fm;
    pipe_t                d;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_WIDTH'(MAX_WIDTH);
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    always_comb
    begin
        op = op_t'(kind);
        fm = fmt_t'(number_format);
        if (width_reg < CFG_WIDTH'(2))
            n = CFG_WIDTH'(2);
        else if (width_reg > CFG_WIDTH'(MAX_WIDTH))
            n = CFG_WIDTH'(MAX_WIDTH);
        else
            n = width_reg;
        m      = {MAX_WIDTH{1'b1}} >> (CFG_WIDTH'(MAX_WIDTH) - n);
        mm     = m >> 1;
        sgnbit = m ^ mm;
        a      = operand_a & m;
        b      = operand_b & m;
        sa     = |(a & sgnbit);
        sb     = |(b & sgnbit);
        case (fm)
            FMT_SM:  begin ma = a & mm; mb = b & mm; end
            FMT_OC:  begin ma = sa ? (~a & m) : a; mb = sb ? (~b & m) : b; end
            FMT_TC:  begin ma = sa ? ((~a + 1'b1) & m) : a; mb = sb ? ((~b + 1'b1) & m) : b; end
            default: begin ma = a; mb = b; end
        endcase

        d      = '0;
        d.kind = op;
        d.fmt  = fm;
        d.n    = n;
        d.sa   = sa;
        d.sb   = sb;
        d.a_nz = |a;
        d.b_nz = |b;
        d.ma   = ma;
        d.mb   = mb;
        d.asr  = '0;
        d.ast  = ST_OK;

        sbe = sb ^ (op == OP_SUB);
        s   = {1'b0, ma} + {1'b0, mb};
        bb  = (op == OP_SUB) ? (~b & m) : b;
        sbb = |(bb & sgnbit);
        t   = {1'b0, a} + {1'b0, bb};
        t1  = (t > {1'b0, m}) ? ((t[MAX_WIDTH-1:0] & m) + 1'b1) : t[MAX_WIDTH-1:0];
        tt  = (op == OP_SUB) ? ((a + (~b & m) + 1'b1) & m) : ((a + b) & m);
        ts  = |(t1 & sgnbit);

        case (fm)
            FMT_UNS:
            begin
                if (op == OP_SUB)
                begin
                    if (a < b) d.ast = ST_UNF;
                    else       d.asr = a - b;
                end
                else
                begin
                    if (t > {1'b0, m}) d.ast = ST_OVF;
                    else               d.asr = t[MAX_WIDTH-1:0];
                end
            end
            FMT_SM:
            begin
                if (sa == sbe)
                begin
                    if (s > {1'b0, mm}) d.ast = ST_OVF;
                    else d.asr = (sa ? sgnbit : '0) | s[MAX_WIDTH-1:0];
                end
                else if (ma > mb)
                    d.asr = (sa ? sgnbit : '0) | (ma - mb);
                else if (ma < mb)
                    d.asr = (sbe ? sgnbit : '0) | (mb - ma);
            end
            FMT_OC:
            begin
                if (sa == sbb && ts != sa) d.ast = ST_OVF;
                else                      d.asr = t1;
            end
            default:
            begin
                // subtract overflows on opposite signs, add on equal signs
                if (((op == OP_SUB) ? (sa != sb) : (sa == sb)) && (|(tt & sgnbit)) != sa)
                    d.ast = ST_OVF;
                else
                    d.asr = tt;
            end
        endcase
    end

    // next values for every stage
    always_comb
    begin
        logic [MAX_WIDTH:0]    rt;
        logic                  ge;
        logic [MAX_WIDTH-1:0]  mq, sgq, q;
        logic [PROD_WIDTH-1:0] m2, prod, r;
        logic [6:0]            n2;
        logic                  neg;
        status_t               sx;
        pipe_t                 p;

        stg_next[0] = d;

        stg_next[1]      = stg_reg[0];
        stg_next[1].prod = PROD_WIDTH'(stg_reg[0].ma) * PROD_WIDTH'(stg_reg[0].mb);
        stg_next[1].rem  = '0;
        stg_next[1].dvd  = stg_reg[0].ma;
        stg_next[1].q    = '0;

        for (int k = 2; k < NUM_STAGES - 1; k++)
        begin
            p  = stg_reg[k-1];
            rt = {p.rem, p.dvd[MAX_WIDTH-1]};
            ge = rt >= {1'b0, p.mb};
            p.rem = ge ? MAX_WIDTH'(rt - {1'b0, p.mb}) : rt[MAX_WIDTH-1:0];
            p.dvd = p.dvd << 1;
            p.q   = {p.q[MAX_WIDTH-2:0], ge};
            stg_next[k] = p;
        end

        p    = stg_reg[NUM_STAGES-2];
        mq   = {MAX_WIDTH{1'b1}} >> (CFG_WIDTH'(MAX_WIDTH) - p.n);
        sgq  = mq ^ (mq >> 1);
        n2   = {p.n, 1'b0};
        m2   = {PROD_WIDTH{1'b1}} >> (7'(PROD_WIDTH) - n2);
        prod = p.prod;
        q    = p.q;
        neg  = p.sa ^ p.sb;
        r    = '0;
        sx   = ST_OK;
        if (p.kind == OP_ADD || p.kind == OP_SUB)
        begin
            r  = PROD_WIDTH'(p.asr);
            sx = p.ast;
        end
        else if (p.kind == OP_MUL)
        begin
            case (p.fmt)
                FMT_SM:
                    if (p.a_nz && p.b_nz)
                        r = prod | (neg ? (PROD_WIDTH'(1) << (n2 - 7'd2)) : '0);
                FMT_OC:
                    if (p.a_nz && p.b_nz)
                        r = neg ? (~prod & m2) : prod;
                FMT_TC:
                    r = neg ? ((~prod + 1'b1) & m2) : prod;
                default:
                    r = prod;
            endcase
        end
        else if (p.mb == '0)
            sx = ST_DIVZ;
        else
        begin
            case (p.fmt)
                FMT_SM:
                    if (q != '0)
                        r = PROD_WIDTH'(q | (neg ? sgq : '0));
                FMT_OC:
                    r = PROD_WIDTH'(neg ? (~q & mq) : q);
                FMT_TC:
                    if (!neg && q > (mq >> 1))
                        sx = ST_OVF;
                    else
                        r = PROD_WIDTH'(neg ? ((~q + 1'b1) & mq) : q);
                default:
                    r = PROD_WIDTH'(q);
            endcase
        end
        if (sx != ST_OK)
            r = '0;
        p.res = r;
        p.st  = sx;
        stg_next[NUM_STAGES-1] = p;
    end

    // per-stage ready: a stage takes new data when empty or when it drains
    always_comb
    begin
        rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NUM_STAGES; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
            stg_reg[0] <= stg_next[0];
        for (int k = 1; k < NUM_STAGES; k++)
            if (rdy[k] && vld_reg[k-1])
                stg_reg[k] <= stg_next[k];
    end

    assign in_ready     = rdy[0];
    assign out_valid    = vld_reg[NUM_STAGES-1];
    assign result_value = stg_reg[NUM_STAGES-1].res;
    assign status       = stg_reg[NUM_STAGES-1].st;

endmodule

@@ design/mfalu_checker.sv @@
// Port-level checks for the multi-format integer ALU core, bound to the core module.
// Depends on mfalu_pkg.
module mfalu_checker
    import mfalu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [PROD_WIDTH-1:0] result_value,
    input logic [1:0]            status
);

    // held result may not vanish before its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_value == '0)
        else $error("error status with nonzero value");

    // an empty or draining output stage must leave the input open
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule

bind multi_format_integer_alu_core mfalu_checker u_mfalu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
);
